// File: sv/jse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package jse_pkg;

  localparam int unsigned PosW = 20;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned SeqIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegOutputLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] RegCountOnly = 1'b1;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChU = 8'h75;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChUpperA = 8'h41;

  // what the back end does with one queued command
  typedef enum logic [1:0] {
    KindPass = 2'd0,  // byte as is
    KindPair = 2'd1,  // backslash + second byte
    KindUni  = 2'd2,  // \u00XX
    KindNone = 2'd3   // single result without a byte
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;   // raw byte, or escape letter for pairs
    logic [PosW-1:0] total;  // base position for emits, reported count otherwise
    logic            trunc;
  } cmd_t;

  function automatic logic [7:0] esc_letter(input logic [7:0] b);
    logic [7:0] l;
    case (b)
      8'h08:   l = 8'h62;  // b
      8'h0C:   l = 8'h66;  // f
      8'h0A:   l = 8'h6E;  // n
      8'h0D:   l = 8'h72;  // r
      8'h09:   l = 8'h74;  // t
      ChQuote, ChBslash, ChSlash: l = b;
      default: l = 8'h00;
    endcase
    return l;
  endfunction

  function automatic kind_e esc_kind(input logic [7:0] b);
    kind_e k;
    if (esc_letter(b) != 8'h00) begin
      k = KindPair;
    end else if (b >= ChSpace) begin
      k = KindPass;
    end else begin
      k = KindUni;
    end
    return k;
  endfunction

  function automatic logic [SeqIdxW-1:0] esc_len(input kind_e k);
    logic [SeqIdxW-1:0] n;
    case (k)
      KindPair: n = 3'd2;
      KindUni:  n = 3'd6;
      default:  n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] c;
    if (v >= 4'd10) begin
      c = ChUpperA + {4'd0, v} - 8'd10;
    end else begin
      c = ChZero + {4'd0, v};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/jse_front.sv
`timescale 1ns / 1ps
`default_nettype none
module jse_front
  import jse_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                push_i,
  input  wire logic [7:0]          in_byte_i,
  input  wire logic                end_of_string_i,
  output cmd_t                     cmd_o
);

  logic [PosW-1:0] limit_q;
  logic            count_only_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            stopped_q, stopped_d;

  kind_e           kind;
  logic [PosW:0]   sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= PosMax;
      count_only_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegOutputLimit: limit_q <= cfg_data_i[PosW-1:0];
        RegCountOnly:   count_only_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    kind      = esc_kind(in_byte_i);
    sum       = {1'b0, pos_q} + {{(PosW+1-SeqIdxW){1'b0}}, esc_len(kind)};
    pos_d     = pos_q;
    stopped_d = stopped_q;
    cmd_o.kind  = KindNone;
    cmd_o.data  = (kind == KindPair) ? esc_letter(in_byte_i) : in_byte_i;
    cmd_o.total = pos_q;
    cmd_o.trunc = 1'b1;
    if (count_only_q) begin
      pos_d       = sum[PosW] ? PosMax : sum[PosW-1:0];
      cmd_o.total = pos_d;
      cmd_o.trunc = stopped_q;
    end else if (stopped_q) begin
      // report only
    end else if (sum > {1'b0, limit_q}) begin
      stopped_d = 1'b1;
    end else begin
      cmd_o.kind  = kind;
      cmd_o.trunc = 1'b0;
      pos_d       = sum[PosW-1:0];
    end
    if (end_of_string_i) begin
      pos_d     = '0;
      stopped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      stopped_q <= 1'b0;
    end else if (push_i) begin
      pos_q     <= pos_d;
      stopped_q <= stopped_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/jse_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module jse_queue
  import jse_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      push_cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  cmd_t       entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

// File: sv/jse_back.sv
`timescale 1ns / 1ps
`default_nettype none
module jse_back
  import jse_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         empty_i,
  input  cmd_t              head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              run_last_o,
  output logic [PosW-1:0]   total_length_o,
  output logic              truncated_o
);

  logic [SeqIdxW-1:0] idx_q;
  logic               valid_q;
  logic [7:0]         byte_q;
  logic               bvalid_q, last_q, trunc_q;
  logic [PosW-1:0]    total_q;

  logic               advance, take, last;
  logic [7:0]         byte_d;
  logic [PosW-1:0]    total_d;

  assign advance = !valid_q || out_ready_i;
  assign take    = advance && !empty_i;
  assign last    = (idx_q == esc_len(head_i.kind) - 3'd1);
  assign pop_o   = take && last;

  always_comb begin
    byte_d = 8'h00;
    case (head_i.kind)
      KindPass: byte_d = head_i.data;
      KindPair: byte_d = (idx_q == 3'd0) ? ChBslash : head_i.data;
      KindUni: begin
        case (idx_q)
          3'd0:    byte_d = ChBslash;
          3'd1:    byte_d = ChU;
          3'd4:    byte_d = hex_digit(head_i.data[7:4]);
          3'd5:    byte_d = hex_digit(head_i.data[3:0]);
          default: byte_d = ChZero;
        endcase
      end
      default: byte_d = 8'h00;
    endcase
    if (head_i.kind == KindNone) begin
      total_d = head_i.total;
    end else begin
      total_d = head_i.total + {{(PosW-SeqIdxW){1'b0}}, idx_q} + {{(PosW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (advance) valid_q <= !empty_i;
      if (take) idx_q <= last ? '0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q   <= byte_d;
      bvalid_q <= (head_i.kind != KindNone);
      last_q   <= last;
      total_q  <= total_d;
      trunc_q  <= head_i.trunc;
    end
  end

  assign out_valid_o    = valid_q;
  assign out_byte_o     = byte_q;
  assign byte_valid_o   = bvalid_q;
  assign run_last_o     = last_q;
  assign total_length_o = total_q;
  assign truncated_o    = trunc_q;

endmodule
`default_nettype wire

// File: sv/json_string_escaper.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming JSON string escaper. Each accepted input byte yields one output
// transaction per escaped byte: plain bytes yield one, two-character escapes
// (\" \\ \/ \b \f \n \r \t) yield two and other control bytes (\u00XX) six,
// all through the single output byte register of the back end. The front end
// tracks position and truncation at accept time and feeds a 2-entry command
// queue, so plain text streams at one byte per cycle while out_ready_i is high.
// When stopped or in count-only mode a byte yields one transaction with
// byte_valid_o low. Position and truncation clear after an end_of_string_i byte.
module json_string_escaper
  import jse_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          in_byte_i,
  input  wire logic                end_of_string_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic                     byte_valid_o,
  output logic                     run_last_o,
  output logic [PosW-1:0]          total_length_o,
  output logic                     truncated_o
);

  cmd_t front_cmd, head;
  logic push, pop, full, empty;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;
  assign push        = in_valid_i && !full;

  jse_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push_i          (push),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .cmd_o           (front_cmd)
  );

  jse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  jse_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .run_last_o     (run_last_o),
    .total_length_o (total_length_o),
    .truncated_o    (truncated_o)
  );

endmodule
`default_nettype wire
